/* design/pfe_pkg.sv */
// shared types and constants for the postfix expression evaluator
// no dependencies; imported by pfe_div, postfix_expression_evaluator_unit and its testbench
package pfe_pkg;

    localparam int DATA_W = 32;

    // character codes
    localparam logic [7:0] CHAR_END   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DIG0  = 8'h30;
    localparam logic [7:0] CHAR_DIG9  = 8'h39;

    // value of an empty pop
    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef logic [DATA_W-1:0] t_word;

    // sticky error flags of one expression
    typedef struct packed {
        logic div_zero;
        logic overflow;
        logic underflow;
    } t_flags;

endpackage

/* design/pfe_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module pfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/pfe_div.sv */
// signed 32-bit divider, restoring, one quotient bit per cycle
// depends on pfe_pkg; divisor must be nonzero, truncates toward zero
module pfe_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  pfe_pkg::t_word i_dividend,
    input  pfe_pkg::t_word i_divisor,
    output logic          o_done,
    output pfe_pkg::t_word o_quotient
);
    import pfe_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_rem;
    t_word            r_quo;
    t_word            r_dvs;
    logic             r_neg;
    logic [DATA_W:0]  w_sh;
    logic [DATA_W:0]  w_diff;

    // shift in next dividend bit and trial subtract
    assign w_sh   = {r_rem, r_quo[DATA_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath on magnitudes
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_dvs <= i_divisor[DATA_W-1] ? (~i_divisor + 1'b1) : i_divisor;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= w_diff[DATA_W] ? w_sh[DATA_W-1:0] : w_diff[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], ~w_diff[DATA_W]};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

/* design/postfix_expression_evaluator_unit.sv */
// postfix expression evaluator: one character per beat, value stack in ram
// depends on pfe_pkg, pfe_ram, pfe_div
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  char in  | in        | i_valid / o_ready  | i_char_code
//  result   | out       | o_valid / i_ready  | o_result_value, o_*_seen flags
//
// digit, space: idle only; end character: pop_t, pop_s, out, held while a result waits;
// + - * and unknown characters: pop_t, pop_s, exec, push; / adds div for a nonzero divisor.
// the steps are set by the single ram port pair: each pop is one read, each push one write.
// reset clears the stack count, accumulator, last result and flags; ram is not cleared.
// a result beat holds in its output register; a further end character waits until it is taken.
module postfix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_char_code,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [31:0]         o_result_value,
    output logic                       o_underflow_seen,
    output logic                       o_overflow_seen,
    output logic                       o_div_zero_seen
);
    import pfe_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_T,
        S_POP_S,
        S_EXEC,
        S_DIV,
        S_PUSH,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [7:0]       r_char;
    logic [CNT_W-1:0] r_count;
    t_word            r_accum;
    logic             r_in_number;
    t_word            r_last;
    t_flags           r_flags;
    t_word            r_t;
    t_word            r_res;
    logic             r_from_mem;
    logic             r_o_valid;
    t_word            r_o_value;
    t_flags           r_o_flags;

    logic             w_accept;
    logic             w_digit;
    t_word            n_accum;
    t_word            w_s;
    t_word            w_t;
    logic             w_we;
    logic [ADDR_W-1:0] w_waddr;
    t_word            w_wdata;
    logic             w_re;
    logic [ADDR_W-1:0] w_raddr;
    t_word            w_rdata;
    logic             w_div_start;
    logic             w_div_done;
    t_word            w_quot;

    assign w_accept = i_valid && o_ready;
    assign w_digit  = (i_char_code >= CHAR_DIG0) && (i_char_code <= CHAR_DIG9);

    // digit accumulation: accum * 10 + digit, wrapping
    always_comb begin
        t_word base;
        base    = r_in_number ? r_accum : '0;
        n_accum = (base << 3) + (base << 1) + {24'd0, i_char_code - CHAR_DIG0};
    end

    // popped values: ram data when a read was issued, else the empty value
    assign w_t = r_from_mem ? w_rdata : r_t;
    assign w_s = r_from_mem ? w_rdata : EMPTY_VALUE;

    // ram port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[ADDR_W-1:0];
        w_wdata = r_accum;
        w_re    = 1'b0;
        w_raddr = ADDR_W'(r_count - 1'b1);
        if (r_state == S_IDLE && w_accept && !w_digit && r_in_number && r_count < FULL) begin
            w_we = 1'b1;
        end
        if (r_state == S_PUSH && r_count < FULL) begin
            w_we    = 1'b1;
            w_wdata = r_res;
        end
        if ((r_state == S_POP_T || (r_state == S_POP_S && r_char != CHAR_END))
            && r_count != '0) begin
            w_re = 1'b1;
        end
    end

    assign w_div_start = (r_state == S_EXEC) && (r_char == CHAR_SLASH) && (r_t != '0);

    pfe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pfe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_s),
        .i_divisor  (r_t),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // sequencer, stack state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_accum     <= '0;
            r_in_number <= 1'b0;
            r_last      <= '0;
            r_flags     <= '0;
            r_from_mem  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            // result beat taken; the end state reloads the register itself
            if (r_o_valid && i_ready && r_state != S_OUT) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_char <= i_char_code;
                        if (w_digit) begin
                            r_accum     <= n_accum;
                            r_in_number <= 1'b1;
                        end else begin
                            // close an open number with a push
                            if (r_in_number) begin
                                r_in_number <= 1'b0;
                                if (r_count < FULL) begin
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_flags.overflow <= 1'b1;
                                end
                            end
                            if (i_char_code != CHAR_SPACE) begin
                                r_state <= S_POP_T;
                            end
                        end
                    end
                end
                S_POP_T: begin
                    r_t <= EMPTY_VALUE;
                    if (r_count != '0) begin
                        r_count    <= r_count - 1'b1;
                        r_from_mem <= 1'b1;
                    end else begin
                        r_from_mem      <= 1'b0;
                        r_flags.underflow <= 1'b1;
                    end
                    r_state <= S_POP_S;
                end
                S_POP_S: begin
                    r_t <= w_t;
                    if (r_char == CHAR_END) begin
                        r_from_mem <= 1'b0;
                        r_state    <= S_OUT;
                    end else begin
                        if (r_count != '0) begin
                            r_count    <= r_count - 1'b1;
                            r_from_mem <= 1'b1;
                        end else begin
                            r_from_mem      <= 1'b0;
                            r_flags.underflow <= 1'b1;
                        end
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_from_mem <= 1'b0;
                    r_state    <= S_PUSH;
                    case (r_char)
                        CHAR_PLUS:  r_res <= w_s + r_t;
                        CHAR_MINUS: r_res <= w_s - r_t;
                        CHAR_STAR:  r_res <= w_s * r_t;
                        CHAR_SLASH: begin
                            if (r_t == '0) begin
                                r_res            <= '0;
                                r_flags.div_zero <= 1'b1;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        default:    r_res <= r_last;
                    endcase
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res   <= w_quot;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    r_last <= r_res;
                    if (r_count < FULL) begin
                        r_count <= r_count + 1'b1;
                    end else begin
                        r_flags.overflow <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_OUT: begin
                    // emit once the output register is free, then clear the expression
                    if (!r_o_valid || i_ready) begin
                        r_o_valid   <= 1'b1;
                        r_o_value   <= r_t;
                        r_o_flags   <= r_flags;
                        r_count     <= '0;
                        r_accum     <= '0;
                        r_in_number <= 1'b0;
                        r_last      <= '0;
                        r_flags     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_result_value   = r_o_value;
    assign o_underflow_seen = r_o_flags.underflow;
    assign o_overflow_seen  = r_o_flags.overflow;
    assign o_div_zero_seen  = r_o_flags.div_zero;

endmodule

/* dv/postfix_expression_evaluator_unit_tb.sv */
// testbench for postfix_expression_evaluator_unit: streams character beats, checks result beats
// depends on pfe_pkg and the evaluator rtl; results are predicted by a behavioural stack model
module postfix_expression_evaluator_unit_tb;
    import pfe_pkg::*;

    localparam int DEPTH         = 32;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 60;

    // a character outside every known class, also the all-ones code
    localparam logic [7:0] CHAR_ALL_ONES = 8'hFF;

    typedef struct packed {
        t_word  value;
        t_flags flags;
    } t_outcome;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic [7:0]         i_char_code = '0;
    logic               i_ready     = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic signed [31:0] o_result_value;
    logic               o_underflow_seen;
    logic               o_overflow_seen;
    logic               o_div_zero_seen;

    postfix_expression_evaluator_unit #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_char_code      (i_char_code),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_value   (o_result_value),
        .o_underflow_seen (o_underflow_seen),
        .o_overflow_seen  (o_overflow_seen),
        .o_div_zero_seen  (o_div_zero_seen)
    );

    // predicted evaluator state
    t_word    calc_stack [DEPTH];
    int       calc_depth;
    t_word    calc_accum;
    bit       calc_in_number;
    t_word    calc_last;
    t_flags   calc_flags;
    t_outcome pending_results [$];

    int error_count = 0;
    int beats_sent  = 0;
    bit gaps_on     = 1'b1;
    int burst_left  = 0;
    int idle_cycles = 0;
    int rx_mode     = 0;
    int rx_stall    = 0;
    int rx_phase    = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void calc_clear();
        calc_depth     = 0;
        calc_accum     = '0;
        calc_in_number = 1'b0;
        calc_last      = '0;
        calc_flags     = '0;
    endfunction

    function automatic void calc_push(t_word v);
        if (calc_depth < DEPTH) begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end else begin
            calc_flags.overflow = 1'b1;
        end
    endfunction

    function automatic t_word calc_pop();
        if (calc_depth == 0) begin
            calc_flags.underflow = 1'b1;
            return EMPTY_VALUE;
        end
        calc_depth--;
        return calc_stack[calc_depth];
    endfunction

    // truncating signed divide on magnitudes, wraps for most negative over minus one
    function automatic t_word signed_quotient(t_word s, t_word t);
        t_word ms, mt, q;
        ms = s[31] ? (~s + 1'b1) : s;
        mt = t[31] ? (~t + 1'b1) : t;
        q  = ms / mt;
        return (s[31] ^ t[31]) ? (~q + 1'b1) : q;
    endfunction

    // advance the prediction by one accepted character
    function automatic void calc_char(logic [7:0] c);
        t_word    top_v, sec_v, res;
        t_outcome o;
        if (c >= CHAR_DIG0 && c <= CHAR_DIG9) begin
            if (!calc_in_number) begin
                calc_accum     = '0;
                calc_in_number = 1'b1;
            end
            calc_accum = calc_accum * 32'd10 + {24'd0, c - CHAR_DIG0};
            return;
        end
        if (calc_in_number) begin
            calc_push(calc_accum);
            calc_in_number = 1'b0;
        end
        if (c == CHAR_END) begin
            o.value = calc_pop();
            o.flags = calc_flags;
            pending_results.push_back(o);
            calc_clear();
            return;
        end
        if (c == CHAR_SPACE)
            return;
        top_v = calc_pop();
        sec_v = calc_pop();
        case (c)
            CHAR_PLUS:  res = sec_v + top_v;
            CHAR_MINUS: res = sec_v - top_v;
            CHAR_STAR:  res = sec_v * top_v;
            CHAR_SLASH: begin
                if (top_v == '0) begin
                    res = '0;
                    calc_flags.div_zero = 1'b1;
                end else begin
                    res = signed_quotient(sec_v, top_v);
                end
            end
            default:    res = calc_last;
        endcase
        calc_last = res;
        calc_push(res);
    endfunction

    // one character beat, with sender bursts and gaps
    task automatic send_char(input logic [7:0] c);
        if (gaps_on && burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        i_valid     <= 1'b1;
        i_char_code <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        calc_char(c);
        beats_sent++;
    endtask

    task automatic send_expression(input string s);
        foreach (s[i])
            send_char(s[i]);
        send_char(CHAR_END);
    endtask

    // hold the sender off until every predicted result has been taken
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [7:0] random_operator();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1:    c = CHAR_PLUS;
            2, 3:    c = CHAR_MINUS;
            4, 5:    c = CHAR_STAR;
            6, 7:    c = CHAR_SLASH;
            default: begin
                c = 8'($urandom_range(1, 255));
                while ((c >= CHAR_DIG0 && c <= CHAR_DIG9) || c == CHAR_SPACE ||
                       c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR ||
                       c == CHAR_SLASH)
                    c = 8'($urandom_range(1, 255));
            end
        endcase
        return c;
    endfunction

    // mostly short numbers, some zeros for divide by zero, some long runs that wrap
    task automatic send_number();
        int digits;
        bit zero;
        zero   = ($urandom_range(0, 9) == 0);
        digits = zero ? 1 : (($urandom_range(0, 7) == 0) ? $urandom_range(10, 12)
                                                         : $urandom_range(1, 3));
        repeat (digits)
            send_char(zero ? CHAR_DIG0 : CHAR_DIG0 + 8'($urandom_range(0, 9)));
    endtask

    // postfix expression with random operands; noise, extra operators or no reduction break it
    task automatic send_random_expression(input int operands, input int push_pct,
                                          input int noise_pct, input int extra_ops,
                                          input bit reduce);
        int left, depth;
        bit need_space;
        left       = operands;
        depth      = 0;
        need_space = 1'b0;
        while (left > 0 || (reduce && depth > 1)) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_char(8'($urandom_range(1, 255)));
                need_space = 1'b1;
            end else if (left > 0 && (depth < 2 || $urandom_range(0, 99) < push_pct)) begin
                if (need_space || $urandom_range(0, 7) == 0)
                    send_char(CHAR_SPACE);
                send_number();
                left--;
                depth++;
                need_space = 1'b1;
            end else begin
                send_char(random_operator());
                depth--;
                need_space = 1'b0;
            end
        end
        repeat (extra_ops)
            send_char(random_operator());
        send_char(CHAR_END);
    endtask

    // empty stack, digits right before the end, divide by zero, unknown character,
    // negative truncation and most negative over minus one
    task automatic test_directed_cases();
        send_char(CHAR_END);
        send_expression("42");
        send_char(CHAR_DIG0 + 8'd7);
        send_char(CHAR_SPACE);
        send_char(CHAR_DIG0);
        send_char(CHAR_SLASH);
        send_char(CHAR_ALL_ONES);
        send_char(CHAR_END);
        send_expression("0 7-2/3*5+");
        send_expression("2147483648 0 1-/");
    endtask

    // push past the stack depth, then one operator on the full stack
    task automatic test_stack_overflow();
        for (int i = 0; i < DEPTH + 2; i++) begin
            send_char(CHAR_DIG0 + 8'(i % 10));
            send_char(CHAR_SPACE);
        end
        send_char(CHAR_STAR);
        send_char(CHAR_END);
    endtask

    task automatic test_random_expressions(input int beats);
        int stop_at, kind, expr_count;
        stop_at    = beats_sent + beats;
        expr_count = 0;
        while (beats_sent < stop_at) begin
            if (expr_count % 40 == 39)
                gaps_on = ($urandom_range(0, 2) != 0);
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                send_random_expression($urandom_range(30, 40), 95, 0, 0, 1'b1);
            end else if (kind <= 2) begin
                send_random_expression($urandom_range(0, 5), 60, 15, $urandom_range(0, 3),
                                       1'($urandom_range(0, 1)));
            end else if (kind == 3) begin
                repeat ($urandom_range(1, 8))
                    send_char(8'($urandom_range(1, 255)));
                send_char(CHAR_END);
            end else begin
                send_random_expression($urandom_range(1, 6), 60, 0, 0, 1'b1);
            end
            expr_count++;
        end
    endtask

    // receiver: always ready, random, or long stalls, with a new mode drawn each time rx_phase wraps
    always @(posedge i_clk) begin
        rx_phase <= (rx_phase + 1) % 256;
        if (rx_phase == 0)
            rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (rx_stall != 0) begin
                    rx_stall <= rx_stall - 1;
                    i_ready  <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        rx_stall <= $urandom_range(1, 24);
                end
            end
        endcase
    end

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no expression pending: value %0d", o_result_value);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result_value !== want.value) begin
                    $error("result_value: expected %0d, got %0d",
                           $signed(want.value), o_result_value);
                    error_count++;
                end
                if (o_underflow_seen !== want.flags.underflow) begin
                    $error("underflow_seen: expected %0b, got %0b",
                           want.flags.underflow, o_underflow_seen);
                    error_count++;
                end
                if (o_overflow_seen !== want.flags.overflow) begin
                    $error("overflow_seen: expected %0b, got %0b",
                           want.flags.overflow, o_overflow_seen);
                    error_count++;
                end
                if (o_div_zero_seen !== want.flags.div_zero) begin
                    $error("div_zero_seen: expected %0b, got %0b",
                           want.flags.div_zero, o_div_zero_seen);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("postfix_expression_evaluator_unit_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        calc_clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_stack_overflow();
        test_random_expressions(600);
        wait_results_drained();
        test_random_expressions(640);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("postfix_expression_evaluator_unit_tb: PASS");
        else
            $display("postfix_expression_evaluator_unit_tb: FAIL");
        $finish;
    end

endmodule
